// File: rtl/sca_pkg.sv
// ----------------------------------------------------------------------------
// sca_pkg
// Widths, fixed-point constants and coefficients of the cubic sine pipeline.
// ----------------------------------------------------------------------------
package sca_pkg;

    // Angle format Q(ANGLE_INT_BITS).(ANGLE_FRAC_BITS), result Q2.(OUT_FRAC_BITS)
    localparam int ANGLE_INT_BITS  = 10;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int ANGLE_W         = ANGLE_INT_BITS + ANGLE_FRAC_BITS;
    localparam int SINE_W          = 16;

    // Internal constant precision (Q.24)
    localparam int CK       = 24;
    localparam int PROD1_W  = ANGLE_W + CK;       // angle * 2/pi
    localparam int QUAD_LSB = ANGLE_FRAC_BITS + CK;
    localparam int R_W      = CK + 1;             // residual, below pi/2
    localparam int PROD2_W  = CK + R_W;           // fraction * pi/2
    localparam int R2_W     = CK + 2;             // r^2, below 2.47
    localparam int R3_W     = CK + 3;             // r^3, below 3.88
    localparam int SUM_W    = 2 * CK + 2;         // polynomial terms in Q.48
    localparam int DROP     = 2 * CK - OUT_FRAC_BITS;
    localparam int MAG_W    = SUM_W + 1 - DROP;   // rounded magnitude
    localparam int NSTG     = 9;                  // pipeline depth

    localparam logic [CK-1:0]  INV_HALFPI_Q = 24'd10680707;
    localparam logic [R_W-1:0] HALFPI_Q     = 25'd26353589;
    localparam logic [R_W-1:0] COEF_A_MAG   = 25'd16823186;
    localparam logic [CK-1:0]  COEF_B_MAG   = 24'd493250;
    localparam logic [CK-1:0]  COEF_C_MAG   = 24'd2189427;

    localparam int SAT_LIM_I = ((1 << OUT_FRAC_BITS) > 32767) ? 32767 : (1 << OUT_FRAC_BITS);
    localparam logic [MAG_W-1:0] SAT_LIM = MAG_W'(SAT_LIM_I);

endpackage

// File: rtl/sine_cubic_approx.sv
// ----------------------------------------------------------------------------
// sine_cubic_approx
// Pipelined sine of a nonnegative angle by quadrant folding and a cubic fit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  i_valid / o_ready carries one item: i_angle, radians in
//   unsigned Q10.16. Output channel o_valid / i_ready carries one item per
//   input: o_sine, signed Q2.14, saturated to plus or minus one.
//   Throughput is one item per clock while i_ready is high, set by the
//   nine-stage multiplier pipeline in which every stage holds one item.
//   Each stage advances when it is empty or the stage after it advances, so a
//   stall at i_ready fills bubbles first and then holds every stage; o_ready
//   drops only once all nine stages hold an item. Nothing is lost or repeated.
//   Synchronous reset (i_rst_n low) clears the valid bits; the data registers
//   are not reset, and o_ready is high in the cycle after reset ends.
//   Stages: 0 angle*2/pi, 1 fraction*pi/2, 2 fold, 3 r^2 and a*r, 4 r^3 and
//   b*r^2, 5 c*r^3, 6 sum of negative terms, 7 sign and magnitude,
//   8 round, saturate, apply quadrant sign.
// ----------------------------------------------------------------------------
module sine_cubic_approx (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [sca_pkg::ANGLE_W-1:0]        i_angle,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [sca_pkg::SINE_W-1:0]  o_sine
);
    import sca_pkg::*;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;
    logic [NSTG-1:0] w_vin;

    // stage registers
    logic [1:0]         r_quad0, r_quad1, r_quad2, r_quad3, r_quad4, r_quad5, r_quad6;
    logic [1:0]         r_quad7;
    logic [CK-1:0]      r_frac;
    logic [R_W-1:0]     r_r, r_rf, r_rf3;
    logic [R2_W-1:0]    r_r2;
    logic [R3_W-1:0]    r_r3;
    logic [SUM_W-1:0]   r_pos3, r_pos4, r_pos5, r_pos6;
    logic [SUM_W-1:0]   r_bm, r_bm5, r_cm, r_neg, r_mag;
    logic               r_ngt;
    logic [SINE_W-1:0]  r_sine;

    // combinational paths
    logic [PROD1_W-1:0] w_p1;
    logic [PROD2_W-1:0] w_p2;
    logic [R_W-1:0]     w_rf;
    logic [2*R_W-1:0]   w_sq;
    logic [R2_W+R_W-1:0] w_cu;
    logic [SUM_W:0]     w_rnd;
    logic [MAG_W-1:0]   w_mag, w_sat;
    logic [SINE_W-1:0]  w_sine;

    // Handshake: a stage moves when empty or when its successor moves
    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        w_vin[0] = i_valid;
        for (int k = 1; k < NSTG; k++) begin
            w_vin[k] = r_vld[k-1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NSTG-1];
    assign o_sine  = r_sine;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    // Datapath arithmetic
    always_comb begin
        w_p1  = PROD1_W'(i_angle) * PROD1_W'(INV_HALFPI_Q);
        w_p2  = PROD2_W'(r_frac) * PROD2_W'(HALFPI_Q);
        w_rf  = r_quad1[0] ? (HALFPI_Q - r_r) : r_r;
        w_sq  = (2*R_W)'(r_rf) * (2*R_W)'(r_rf);
        w_cu  = (R2_W+R_W)'(r_r2) * (R2_W+R_W)'(r_rf3);
        // round half up on the magnitude, then saturate
        w_rnd = {1'b0, r_mag} + ((SUM_W+1)'(1) << (DROP - 1));
        w_mag = w_rnd[SUM_W:DROP];
        w_sat = (w_mag > SAT_LIM) ? SAT_LIM : w_mag;
        if (w_sat == '0) begin
            w_sine = '0;
        end else if (r_ngt ^ r_quad7[1]) begin
            w_sine = SINE_W'(0) - SINE_W'(w_sat);
        end else begin
            w_sine = SINE_W'(w_sat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_quad0 <= w_p1[QUAD_LSB +: 2];
            r_frac  <= w_p1[ANGLE_FRAC_BITS +: CK];
        end
        if (w_en[1]) begin
            r_quad1 <= r_quad0;
            r_r     <= w_p2[CK +: R_W];
        end
        if (w_en[2]) begin
            r_quad2 <= r_quad1;
            r_rf    <= w_rf;
        end
        if (w_en[3]) begin
            r_quad3 <= r_quad2;
            r_rf3   <= r_rf;
            r_r2    <= w_sq[CK +: R2_W];
            r_pos3  <= SUM_W'(r_rf) * SUM_W'(COEF_A_MAG);
        end
        if (w_en[4]) begin
            r_quad4 <= r_quad3;
            r_pos4  <= r_pos3;
            r_r3    <= w_cu[CK +: R3_W];
            r_bm    <= SUM_W'(r_r2) * SUM_W'(COEF_B_MAG);
        end
        if (w_en[5]) begin
            r_quad5 <= r_quad4;
            r_pos5  <= r_pos4;
            r_bm5   <= r_bm;
            r_cm    <= SUM_W'(r_r3) * SUM_W'(COEF_C_MAG);
        end
        if (w_en[6]) begin
            r_quad6 <= r_quad5;
            r_pos6  <= r_pos5;
            r_neg   <= r_bm5 + r_cm;
        end
        if (w_en[7]) begin
            r_quad7 <= r_quad6;
            if (r_pos6 >= r_neg) begin
                r_mag <= r_pos6 - r_neg;
                r_ngt <= 1'b0;
            end else begin
                r_mag <= r_neg - r_pos6;
                r_ngt <= 1'b1;
            end
        end
        if (w_en[8]) begin
            r_sine <= w_sine;
        end
    end

`ifndef ASSERT_OFF
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sine <= $signed({1'b0, SAT_LIM}) && o_sine >= -$signed({1'b0, SAT_LIM})))
        else $error("sine beyond saturation limit");

    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NSTG-1] |-> o_ready)
        else $error("ready low with empty output stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> r_vld[0])
        else $error("accepted item missing from first stage");

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> r_rf <= HALFPI_Q)
        else $error("folded residual above pi/2");
`endif

endmodule
